>>> rtl/rrtqs_pkg.sv
// Shared types, codes and constants of the round-robin task queue scheduler.
package rrtqs_pkg;

   localparam int CMD_W      = 2;
   localparam int USER_W     = 4;
   localparam int ID_W       = 16;
   localparam int MS_W       = 32;
   localparam int CODE_W     = 8;
   localparam int NU_W       = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int USER_CNT_W = 7;

   localparam logic [CMD_W-1:0] CMD_ENQUEUE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REPORT   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_USERS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_LIMIT = 2'd2;

   localparam logic [NU_W-1:0] NUM_USERS_RST  = 5'd1;
   localparam logic [MS_W-1:0] QUANTUM_RST    = 32'd1000;
   localparam logic [MS_W-1:0] LONG_LIMIT_RST = 32'd60000;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic            susp;
      logic [MS_W-1:0] total;
   } rec_type;

   typedef struct packed {
      logic [USER_CNT_W-1:0] users;
      logic [MS_W-1:0]       quantum;
      logic [MS_W-1:0]       long_limit;
   } cfg_type;

endpackage

>>> rtl/round_robin_task_queue_scheduler.sv
// Top level: round-robin task queue scheduler sequencer.
//
//  channel  handshake            payload
//  req      start / busy         req_cmd .. req_exit_code
//  rsp      rsp_valid (strobe)   rsp_task_valid .. rsp_overflow
//  csr      csr_valid/csr_ready  csr_index, csr_wdata
//
// Enqueue and report read the descriptor, then update and write back.
// An unused command is answered from idle. Dispatch folds the pointer (pointer mod users),
// scans one queue a cycle past empty queues, pops the first nonempty one and reads its
// record; with nothing to dispatch, it scans every active queue and returns no task.
// One item at a time; busy is high until its result register is loaded.
// Synchronous reset clears control state; descriptors read as empty until written.
// Results are a one-cycle strobe; the receiver cannot stall.
module round_robin_task_queue_scheduler #(
   parameter int MAX_USERS   = 16,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [rrtqs_pkg::CMD_W-1:0]      req_cmd,
   input  logic [rrtqs_pkg::USER_W-1:0]     req_user_index,
   input  logic [rrtqs_pkg::ID_W-1:0]       req_task_id,
   input  logic                             req_task_suspended,
   input  logic [rrtqs_pkg::MS_W-1:0]       req_total_ms_in,
   input  logic [rrtqs_pkg::MS_W-1:0]       req_elapsed_ms,
   input  logic                             req_group_finished,
   input  logic [rrtqs_pkg::CODE_W-1:0]     req_exit_code,
   output logic                             rsp_valid,
   output logic                             rsp_task_valid,
   output logic [rrtqs_pkg::ID_W-1:0]       rsp_task_id_out,
   output logic [rrtqs_pkg::USER_W-1:0]     rsp_user_out,
   output logic                             rsp_suspended_out,
   output logic [rrtqs_pkg::MS_W-1:0]       rsp_total_ms_out,
   output logic                             rsp_requeued,
   output logic                             rsp_long_alert,
   output logic                             rsp_fail_alert,
   output logic                             rsp_overflow,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rrtqs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rrtqs_pkg::MS_W-1:0]       csr_wdata
);

   localparam int UW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
   localparam int NW = $clog2(MAX_USERS + 1);
   localparam int SW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int DEPTH = MAX_USERS * QUEUE_DEPTH;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW = rrtqs_pkg::USER_CNT_W;

   localparam logic [XW-1:0] MU      = XW'(MAX_USERS);
   localparam logic [CW-1:0] QD_CNT  = CW'(QUEUE_DEPTH);
   localparam logic [SW-1:0] QD_LAST = SW'(QUEUE_DEPTH - 1);
   localparam logic [AW-1:0] QD_A    = AW'(QUEUE_DEPTH);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_UPD  = 3'd1;
   localparam logic [2:0] S_MOD  = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_DDQ  = 3'd4;
   localparam logic [2:0] S_DST  = 3'd5;

   rrtqs_pkg::cfg_type cfg;
   rrtqs_pkg::rec_type st_wr_data;
   rrtqs_pkg::rec_type st_rd_data;

   logic [2:0]                        state_ff, state_in;
   logic [rrtqs_pkg::CMD_W-1:0]       cmd_ff, cmd_in;
   logic [rrtqs_pkg::USER_W-1:0]      user_ff, user_in;
   logic [rrtqs_pkg::ID_W-1:0]        id_ff, id_in;
   logic                              susp_ff, susp_in;
   logic [rrtqs_pkg::MS_W-1:0]        tot_ff, tot_in;
   logic [rrtqs_pkg::MS_W-1:0]        el_ff, el_in;
   logic                              fin_ff, fin_in;
   logic [rrtqs_pkg::CODE_W-1:0]      code_ff, code_in;
   logic [UW-1:0]                     cur_ff, cur_in;
   logic [NW-1:0]                     cnt_ff, cnt_in;
   logic [UW-1:0]                     rr_ff, rr_in;
   logic [MAX_USERS-1:0]              nonempty_ff, nonempty_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_task_valid_ff, rsp_task_valid_in;
   logic [rrtqs_pkg::ID_W-1:0]        rsp_id_ff, rsp_id_in;
   logic [rrtqs_pkg::USER_W-1:0]      rsp_user_ff, rsp_user_in;
   logic                              rsp_susp_ff, rsp_susp_in;
   logic [rrtqs_pkg::MS_W-1:0]        rsp_total_ff, rsp_total_in;
   logic                              rsp_requeued_ff, rsp_requeued_in;
   logic                              rsp_long_ff, rsp_long_in;
   logic                              rsp_fail_ff, rsp_fail_in;
   logic                              rsp_overflow_ff, rsp_overflow_in;

   logic                              accept;
   logic [UW-1:0]                     user_q;
   logic                              user_ok;
   logic [rrtqs_pkg::MS_W:0]          sum_wide;
   logic [rrtqs_pkg::MS_W-1:0]        sum_sat;
   logic                              push_req;
   logic                              push_ok;
   logic [XW-1:0]                     cur_x;
   logic [XW-1:0]                     cur_next_x;
   logic [NW-1:0]                     n_users;

   logic                              dq_wr_en;
   logic [UW-1:0]                     dq_wr_addr;
   logic [SW-1:0]                     dq_wr_head;
   logic [SW-1:0]                     dq_wr_tail;
   logic [CW-1:0]                     dq_wr_count;
   logic [UW-1:0]                     dq_rd_addr;
   logic [SW-1:0]                     dq_rd_head;
   logic [SW-1:0]                     dq_rd_tail;
   logic [CW-1:0]                     dq_rd_count;

   logic                              st_wr_en;
   logic [AW-1:0]                     st_wr_addr;
   logic [AW-1:0]                     st_rd_addr;

   rrtqs_csr #(
      .MAX_USERS (MAX_USERS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rrtqs_qdesc_mem #(
      .NUM_Q (MAX_USERS),
      .UW    (UW),
      .SW    (SW),
      .CW    (CW)
   ) u_qdesc (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (dq_wr_en),
      .wr_addr  (dq_wr_addr),
      .wr_head  (dq_wr_head),
      .wr_tail  (dq_wr_tail),
      .wr_count (dq_wr_count),
      .rd_addr  (dq_rd_addr),
      .rd_head  (dq_rd_head),
      .rd_tail  (dq_rd_tail),
      .rd_count (dq_rd_count)
   );

   rrtqs_task_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign n_users = NW'(cfg.users);
   assign cur_x   = XW'(cur_ff);
   assign cur_next_x = cur_x + XW'(1);

   assign user_q  = UW'(user_ff);
   assign user_ok = (XW'(user_ff) < MU);

   assign sum_wide = {1'b0, tot_ff} + {1'b0, el_ff};
   assign sum_sat  = sum_wide[rrtqs_pkg::MS_W] ? '1 : sum_wide[rrtqs_pkg::MS_W-1:0];
   assign push_req = (cmd_ff == rrtqs_pkg::CMD_ENQUEUE) ||
                     (!fin_ff && (el_ff >= cfg.quantum));
   assign push_ok  = push_req && user_ok && (dq_rd_count != QD_CNT);

   assign dq_rd_addr = (state_ff == S_IDLE) ? UW'(req_user_index) : cur_ff;

   assign st_wr_addr    = AW'(user_q) * QD_A + AW'(dq_rd_tail);
   assign st_rd_addr    = AW'(cur_ff) * QD_A + AW'(dq_rd_head);
   assign st_wr_data.id    = id_ff;
   assign st_wr_data.susp  = (cmd_ff == rrtqs_pkg::CMD_ENQUEUE) ? susp_ff : 1'b1;
   assign st_wr_data.total = (cmd_ff == rrtqs_pkg::CMD_ENQUEUE) ? tot_ff : sum_sat;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      user_in     = user_ff;
      id_in       = id_ff;
      susp_in     = susp_ff;
      tot_in      = tot_ff;
      el_in       = el_ff;
      fin_in      = fin_ff;
      code_in     = code_ff;
      cur_in      = cur_ff;
      cnt_in      = cnt_ff;
      rr_in       = rr_ff;
      nonempty_in = nonempty_ff;

      rsp_valid_in      = 1'b0;
      rsp_task_valid_in = rsp_task_valid_ff;
      rsp_id_in         = rsp_id_ff;
      rsp_user_in       = rsp_user_ff;
      rsp_susp_in       = rsp_susp_ff;
      rsp_total_in      = rsp_total_ff;
      rsp_requeued_in   = rsp_requeued_ff;
      rsp_long_in       = rsp_long_ff;
      rsp_fail_in       = rsp_fail_ff;
      rsp_overflow_in   = rsp_overflow_ff;

      dq_wr_en    = 1'b0;
      dq_wr_addr  = user_q;
      dq_wr_head  = dq_rd_head;
      dq_wr_tail  = (dq_rd_tail == QD_LAST) ? '0 : dq_rd_tail + SW'(1);
      dq_wr_count = dq_rd_count + CW'(1);
      st_wr_en    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in  = req_cmd;
               user_in = req_user_index;
               id_in   = req_task_id;
               susp_in = req_task_suspended;
               tot_in  = req_total_ms_in;
               el_in   = req_elapsed_ms;
               fin_in  = req_group_finished;
               code_in = req_exit_code;
               cur_in  = rr_ff;
               cnt_in  = '0;
               case (req_cmd)
                  rrtqs_pkg::CMD_ENQUEUE:  state_in = S_UPD;
                  rrtqs_pkg::CMD_REPORT:   state_in = S_UPD;
                  rrtqs_pkg::CMD_DISPATCH: state_in = S_MOD;
                  default: begin
                     rsp_valid_in      = 1'b1;
                     rsp_task_valid_in = 1'b0;
                     rsp_id_in         = '0;
                     rsp_user_in       = '0;
                     rsp_susp_in       = 1'b0;
                     rsp_total_in      = '0;
                     rsp_requeued_in   = 1'b0;
                     rsp_long_in       = 1'b0;
                     rsp_fail_in       = 1'b0;
                     rsp_overflow_in   = 1'b0;
                  end
               endcase
            end
         end
         S_UPD: begin
            dq_wr_en = push_ok;
            st_wr_en = push_ok;
            if (push_ok) begin
               nonempty_in[user_q] = 1'b1;
            end
            rsp_valid_in      = 1'b1;
            rsp_task_valid_in = 1'b0;
            rsp_susp_in       = 1'b0;
            rsp_overflow_in   = push_req && !push_ok;
            if (cmd_ff == rrtqs_pkg::CMD_ENQUEUE) begin
               rsp_id_in       = '0;
               rsp_user_in     = '0;
               rsp_total_in    = '0;
               rsp_requeued_in = 1'b0;
               rsp_long_in     = 1'b0;
               rsp_fail_in     = 1'b0;
            end else begin
               rsp_id_in       = id_ff;
               rsp_user_in     = user_ff;
               rsp_total_in    = sum_sat;
               rsp_requeued_in = push_ok;
               rsp_long_in     = fin_ff && (sum_sat > cfg.long_limit);
               rsp_fail_in     = fin_ff && (code_ff != '0);
            end
            state_in = S_IDLE;
         end
         S_MOD: begin
            if (cur_x >= cfg.users) begin
               cur_in = UW'(cur_x - cfg.users);
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cnt_ff == n_users) begin
               rsp_valid_in      = 1'b1;
               rsp_task_valid_in = 1'b0;
               rsp_id_in         = '0;
               rsp_user_in       = '0;
               rsp_susp_in       = 1'b0;
               rsp_total_in      = '0;
               rsp_requeued_in   = 1'b0;
               rsp_long_in       = 1'b0;
               rsp_fail_in       = 1'b0;
               rsp_overflow_in   = 1'b0;
               state_in          = S_IDLE;
            end else if (nonempty_ff[cur_ff]) begin
               state_in = S_DDQ;
            end else begin
               cur_in = (cur_next_x == cfg.users) ? '0 : UW'(cur_next_x);
               cnt_in = cnt_ff + NW'(1);
            end
         end
         S_DDQ: begin
            dq_wr_en    = 1'b1;
            dq_wr_addr  = cur_ff;
            dq_wr_head  = (dq_rd_head == QD_LAST) ? '0 : dq_rd_head + SW'(1);
            dq_wr_tail  = dq_rd_tail;
            dq_wr_count = dq_rd_count - CW'(1);
            if (dq_rd_count == CW'(1)) begin
               nonempty_in[cur_ff] = 1'b0;
            end
            rr_in    = (cur_next_x == cfg.users) ? '0 : UW'(cur_next_x);
            state_in = S_DST;
         end
         S_DST: begin
            rsp_valid_in      = 1'b1;
            rsp_task_valid_in = 1'b1;
            rsp_id_in         = st_rd_data.id;
            rsp_user_in       = rrtqs_pkg::USER_W'(cur_ff);
            rsp_susp_in       = st_rd_data.susp;
            rsp_total_in      = st_rd_data.total;
            rsp_requeued_in   = 1'b0;
            rsp_long_in       = 1'b0;
            rsp_fail_in       = 1'b0;
            rsp_overflow_in   = 1'b0;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rr_ff        <= '0;
         nonempty_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rr_ff        <= rr_in;
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff            <= cmd_in;
      user_ff           <= user_in;
      id_ff             <= id_in;
      susp_ff           <= susp_in;
      tot_ff            <= tot_in;
      el_ff             <= el_in;
      fin_ff            <= fin_in;
      code_ff           <= code_in;
      cur_ff            <= cur_in;
      cnt_ff            <= cnt_in;
      rsp_task_valid_ff <= rsp_task_valid_in;
      rsp_id_ff         <= rsp_id_in;
      rsp_user_ff       <= rsp_user_in;
      rsp_susp_ff       <= rsp_susp_in;
      rsp_total_ff      <= rsp_total_in;
      rsp_requeued_ff   <= rsp_requeued_in;
      rsp_long_ff       <= rsp_long_in;
      rsp_fail_ff       <= rsp_fail_in;
      rsp_overflow_ff   <= rsp_overflow_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_task_valid    = rsp_task_valid_ff;
   assign rsp_task_id_out   = rsp_id_ff;
   assign rsp_user_out      = rsp_user_ff;
   assign rsp_suspended_out = rsp_susp_ff;
   assign rsp_total_ms_out  = rsp_total_ff;
   assign rsp_requeued      = rsp_requeued_ff;
   assign rsp_long_alert    = rsp_long_ff;
   assign rsp_fail_alert    = rsp_fail_ff;
   assign rsp_overflow      = rsp_overflow_ff;

`ifndef SYNTHESIS
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (cur_x < cfg.users))
      else $error("scan pointer beyond active users");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DDQ) |-> (dq_rd_count != '0))
      else $error("pop from a queue whose descriptor is empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD) |-> (dq_rd_count <= QD_CNT))
      else $error("queue count above depth");

   a_dispatch_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DST) |=> (rsp_valid && rsp_task_valid))
      else $error("dispatch pop without a valid result");
`endif

endmodule

>>> rtl/rrtqs_csr.sv
// Configuration registers; the effective user count and quantum are clamped.
module rrtqs_csr #(
   parameter int MAX_USERS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rrtqs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rrtqs_pkg::MS_W-1:0]     csr_wdata,
   output rrtqs_pkg::cfg_type             cfg
);

   localparam logic [rrtqs_pkg::USER_CNT_W-1:0] MU =
      rrtqs_pkg::USER_CNT_W'(MAX_USERS);

   logic [rrtqs_pkg::NU_W-1:0]       num_users_ff;
   logic [rrtqs_pkg::MS_W-1:0]       quantum_ff;
   logic [rrtqs_pkg::MS_W-1:0]       long_limit_ff;
   logic [rrtqs_pkg::USER_CNT_W-1:0] nu_ext;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_users_ff  <= rrtqs_pkg::NUM_USERS_RST;
         quantum_ff    <= rrtqs_pkg::QUANTUM_RST;
         long_limit_ff <= rrtqs_pkg::LONG_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rrtqs_pkg::CSR_NUM_USERS:  num_users_ff  <= csr_wdata[rrtqs_pkg::NU_W-1:0];
            rrtqs_pkg::CSR_QUANTUM:    quantum_ff    <= csr_wdata;
            rrtqs_pkg::CSR_LONG_LIMIT: long_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign nu_ext = rrtqs_pkg::USER_CNT_W'(num_users_ff);

   always_comb begin
      if (nu_ext == '0) begin
         cfg.users = rrtqs_pkg::USER_CNT_W'(1);
      end else if (nu_ext > MU) begin
         cfg.users = MU;
      end else begin
         cfg.users = nu_ext;
      end
      cfg.quantum    = (quantum_ff == '0) ? rrtqs_pkg::MS_W'(1) : quantum_ff;
      cfg.long_limit = long_limit_ff;
   end

endmodule

>>> rtl/rrtqs_qdesc_mem.sv
// Queue descriptor memory (head, tail, count) with per-queue valid bits.
module rrtqs_qdesc_mem #(
   parameter int NUM_Q = 16,
   parameter int UW    = 4,
   parameter int SW    = 4,
   parameter int CW    = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [UW-1:0] wr_addr,
   input  logic [SW-1:0] wr_head,
   input  logic [SW-1:0] wr_tail,
   input  logic [CW-1:0] wr_count,
   input  logic [UW-1:0] rd_addr,
   output logic [SW-1:0] rd_head,
   output logic [SW-1:0] rd_tail,
   output logic [CW-1:0] rd_count
);

   localparam int DW = SW + SW + CW;

   logic [DW-1:0]    mem_ff [NUM_Q];
   logic [NUM_Q-1:0] valid_ff;
   logic [DW-1:0]    rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= {wr_head, wr_tail, wr_count};
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign {rd_head, rd_tail, rd_count} = rd_valid_ff ? rd_data_ff : '0;

endmodule

>>> rtl/rrtqs_task_ram.sv
// Task record store, one write port and one registered read port.
module rrtqs_task_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  rrtqs_pkg::rec_type wr_data,
   input  logic [AW-1:0]      rd_addr,
   output rrtqs_pkg::rec_type rd_data
);

   rrtqs_pkg::rec_type mem_ff [DEPTH];
   rrtqs_pkg::rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
